// File: design/dqe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS question encoder package
// Shared widths, register indexes and message framing constants.
// ----------------------------------------------------------------------------
package dqe_pkg;

  localparam int CHAR_W    = 8;
  localparam int WORD_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_QUERY_ID       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FLAGS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUESTION_TYPE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUESTION_CLASS = 2'd3;

  localparam logic [WORD_W-1:0] FLAGS_RESET = 16'h0100;
  localparam logic [WORD_W-1:0] QTYPE_RESET = 16'h0001;
  localparam logic [WORD_W-1:0] QCLASS_RESET = 16'h0001;
  localparam logic [WORD_W-1:0] QDCOUNT     = 16'h0001;

  localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

  localparam int HDR_BYTES  = 12;
  localparam int TAIL_BYTES = 5;

  function automatic logic [CHAR_W-1:0] header_byte(
    input logic [3:0]        pos,
    input logic [WORD_W-1:0] query_id,
    input logic [WORD_W-1:0] flags
  );
    logic [CHAR_W-1:0] b;
    begin
      unique case (pos)
        4'd0:    b = query_id[15:8];
        4'd1:    b = query_id[7:0];
        4'd2:    b = flags[15:8];
        4'd3:    b = flags[7:0];
        4'd4:    b = QDCOUNT[15:8];
        4'd5:    b = QDCOUNT[7:0];
        default: b = '0;
      endcase
      return b;
    end
  endfunction

endpackage

// File: design/dqe_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Name character channel
// Carries one host name character and its end-of-name mark per request.
// ----------------------------------------------------------------------------
interface dqe_char_if import dqe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] name_char;
  logic              name_end;

  modport source (output valid, output name_char, output name_end, input ready);
  modport sink   (input valid, input name_char, input name_end, output ready);
endinterface

// File: design/dqe_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message byte channel
// Carries one byte of the encoded query message per request.
// ----------------------------------------------------------------------------
interface dqe_byte_if import dqe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] msg_byte;
  logic              msg_last;
  logic              label_overflow;

  modport source (output valid, output msg_byte, output msg_last,
                  output label_overflow, input ready);
  modport sink   (input valid, input msg_byte, input msg_last,
                  input label_overflow, output ready);
endinterface

// File: design/dqe_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the 16-bit value written to it.
// ----------------------------------------------------------------------------
interface dqe_cfg_if import dqe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: design/dqe_label_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label buffer memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dqe_label_ram import dqe_pkg::*; #(
  parameter int DEPTH  = 48,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/dns_question_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS question encoder
// Turns a dotted host name, one character per request on name_in, into a DNS
// query message, one byte per request on msg_out.
//
// The first character of a name first produces the 12-byte header. Label
// characters are written into an internal buffer memory; a dot or the final
// character sends the length byte and the buffered bytes, read back one per
// cycle while msg_out is ready. The final character then adds the root byte,
// qtype and qclass, and msg_last marks the last qclass byte. Characters past
// LABEL_MAX in one label are dropped and label_overflow is raised on
// that label's bytes. A character is taken only while no earlier one is
// being sent. A stalled receiver simply holds the sequencer in place.
// Registers are to be written on cfg only while the block is idle; the block
// does not enforce it, and cfg is always ready. Reset restores the register
// defaults and starts a new message.
// ----------------------------------------------------------------------------
module dns_question_encoder_top import dqe_pkg::*; #(
  parameter int LABEL_MAX = 48
) (
  input  logic       clk,
  input  logic       rst,
  dqe_char_if.sink   name_in,
  dqe_byte_if.source msg_out,
  dqe_cfg_if.sink    cfg
);

  localparam int CNT_W  = $clog2(LABEL_MAX + 1);
  localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int IDX_W  = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_LEN,
    S_DATA,
    S_TAIL
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  label_count;
  logic              header_sent;
  logic              overflow_seen;
  logic              cur_flush;
  logic              cur_end;

  logic [WORD_W-1:0] query_id;
  logic [WORD_W-1:0] header_flags;
  logic [WORD_W-1:0] question_type;
  logic [WORD_W-1:0] question_class;

  logic              out_valid;
  logic [CHAR_W-1:0] out_byte;
  logic              out_last;
  logic              out_ovf;

  logic              accept;
  logic              adv;
  logic              load_out;
  logic              is_dot;
  logic              room;
  logic              store;
  logic [CNT_W-1:0]  count_next;
  logic              ovf_next;
  logic              flush_next;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;
  logic [CHAR_W-1:0] tail_byte;
  logic              data_done;

  assign name_in.ready = (state == S_IDLE);
  assign accept        = name_in.valid && name_in.ready;
  assign adv           = !out_valid || msg_out.ready;
  assign load_out      = adv && (state == S_HDR || state == S_LEN ||
                                 state == S_DATA || state == S_TAIL);

  assign is_dot     = (name_in.name_char == DOT_CHAR);
  assign room       = (label_count < CNT_W'(LABEL_MAX));
  assign store      = accept && !is_dot && room;
  assign count_next = store ? label_count + CNT_W'(1) : label_count;
  assign ovf_next   = overflow_seen || (!is_dot && !room);
  assign flush_next = (is_dot || name_in.name_end) && (count_next != '0);

  assign data_done = (idx == IDX_W'(label_count) - IDX_W'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (adv && state == S_LEN) begin
      rd_en = 1'b1;
    end else if (adv && state == S_DATA && !data_done) begin
      rd_en   = 1'b1;
      rd_addr = ADDR_W'(idx + IDX_W'(1));
    end
  end

  always_comb begin
    unique case (idx[2:0])
      3'd0:    tail_byte = '0;
      3'd1:    tail_byte = question_type[15:8];
      3'd2:    tail_byte = question_type[7:0];
      3'd3:    tail_byte = question_class[15:8];
      3'd4:    tail_byte = question_class[7:0];
      default: tail_byte = '0;
    endcase
  end

  dqe_label_ram #(
    .DEPTH  (LABEL_MAX),
    .ADDR_W (ADDR_W)
  ) u_label_ram (
    .clk   (clk),
    .we    (store),
    .waddr (ADDR_W'(label_count)),
    .wdata (name_in.name_char),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_id       <= '0;
      header_flags   <= FLAGS_RESET;
      question_type  <= QTYPE_RESET;
      question_class <= QCLASS_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_QUERY_ID:       query_id       <= cfg.wr_data;
        REG_HEADER_FLAGS:   header_flags   <= cfg.wr_data;
        REG_QUESTION_TYPE:  question_type  <= cfg.wr_data;
        REG_QUESTION_CLASS: question_class <= cfg.wr_data;
      endcase
    end
  end

  assign msg_out.valid          = out_valid;
  assign msg_out.msg_byte       = out_byte;
  assign msg_out.msg_last       = out_last;
  assign msg_out.label_overflow = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      label_count   <= '0;
      header_sent   <= 1'b0;
      overflow_seen <= 1'b0;
      cur_flush     <= 1'b0;
      cur_end       <= 1'b0;
      out_valid     <= 1'b0;
      out_last      <= 1'b0;
      out_ovf       <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (msg_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            label_count   <= count_next;
            overflow_seen <= ovf_next;
            header_sent   <= !name_in.name_end;
            cur_flush     <= flush_next;
            cur_end       <= name_in.name_end;
            idx           <= '0;
            if (!header_sent) begin
              state <= S_HDR;
            end else if (flush_next) begin
              state <= S_LEN;
            end else if (name_in.name_end) begin
              state <= S_TAIL;
            end
          end
        end
        S_HDR: begin
          if (adv) begin
            out_byte  <= header_byte(idx[3:0], query_id, header_flags);
            out_last  <= 1'b0;
            out_ovf   <= 1'b0;
            if (idx == IDX_W'(HDR_BYTES - 1)) begin
              idx <= '0;
              if (cur_flush) begin
                state <= S_LEN;
              end else if (cur_end) begin
                state <= S_TAIL;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_LEN: begin
          if (adv) begin
            out_byte  <= CHAR_W'(label_count);
            out_last  <= 1'b0;
            out_ovf   <= overflow_seen;
            idx       <= '0;
            state     <= S_DATA;
          end
        end
        S_DATA: begin
          if (adv) begin
            out_byte  <= rd_data;
            out_last  <= 1'b0;
            out_ovf   <= overflow_seen;
            if (data_done) begin
              label_count   <= '0;
              overflow_seen <= 1'b0;
              idx           <= '0;
              state         <= cur_end ? S_TAIL : S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        S_TAIL: begin
          if (adv) begin
            out_byte  <= tail_byte;
            out_ovf   <= 1'b0;
            out_last  <= (idx == IDX_W'(TAIL_BYTES - 1));
            if (idx == IDX_W'(TAIL_BYTES - 1)) begin
              idx           <= '0;
              label_count   <= '0;
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end else begin
              idx <= idx + IDX_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
